[hdl/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64 stream decoder
// Status codes, the sextet decode function and the job word handed from
// the front end to the back end through the job queue.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Sticky status reported with the final result of a string
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADCHAR = 2'd1,
    ST_BADPAD  = 2'd2,
    ST_LENGTH  = 2'd3
  } status_t;

  // Decoded character classes beyond the 64 alphabet values
  localparam logic [6:0] SX_PAD = 7'd64;
  localparam logic [6:0] SX_BAD = 7'd65;

  // Configuration register map
  localparam int          CfgAddrW     = 3;
  localparam logic        REG_EXPECTED = 1'b0;
  localparam logic [6:0]  ExpReset     = 7'd32;

  // Job queue between front and back end
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  // One job: up to three bytes of one group plus end-of-string marking
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        last;
    status_t     status;
  } job_t;

  // Map one ASCII character to its sextet, SX_PAD for '=', SX_BAD otherwise
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] v;
    begin
      v = {1'b0, SX_BAD};
      if (ch >= 8'h41 && ch <= 8'h5A) begin
        v = ch - 8'h41;
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
        v = ch - 8'h61 + 8'd26;
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
        v = ch - 8'h30 + 8'd52;
      end else if (ch == 8'h2B) begin
        v = 8'd62;
      end else if (ch == 8'h2F) begin
        v = 8'd63;
      end else if (ch == 8'h3D) begin
        v = {1'b0, SX_PAD};
      end
      return v[6:0];
    end
  endfunction

endpackage

[hdl/b64d_if.sv]
// ----------------------------------------------------------------------------
// b64d_if: stream channels of the base64 stream decoder
// Valid/ready channels for incoming characters and outgoing result words.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, out_byte, byte_valid, out_last, status, input ready);
  modport sink   (input valid, out_byte, byte_valid, out_last, status, output ready);
endinterface

[hdl/b64d_front.sv]
// ----------------------------------------------------------------------------
// b64d_front: character classification and group assembly
// Decodes one character per cycle unless the queue is full, tracks group
// position, padding, byte count, sticky status; pushes jobs for bytes and end.
// ----------------------------------------------------------------------------
module b64d_front #(
  parameter int MAX_OUT_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  b64d_in_if.sink            in_ch,
  input  logic [6:0]         expected_bytes,
  input  logic               q_full,
  output logic               push,
  output b64d_pkg::job_t     job
);

  logic [17:0]         buf_r, buf_nxt;
  logic [1:0]          pos_r, pos_nxt;
  logic [1:0]          pad_r, pad_nxt;
  logic [6:0]          be_r, be_nxt;
  b64d_pkg::status_t   err_r, err_nxt;

  logic                accept;
  logic [6:0]          sx;
  logic                is_pad;
  logic [5:0]          six;
  logic [6:0]          cap;
  logic [6:0]          avail;
  logic [1:0]          count;
  logic [1:0]          nb;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the character
  assign sx     = b64d_pkg::sextet_of(in_ch.in_char);
  assign is_pad = (sx == b64d_pkg::SX_PAD);
  assign six    = is_pad ? 6'd0 : sx[5:0];

  // Byte budget left under the tighter of the two limits
  assign cap   = (32'(expected_bytes) < MAX_OUT_BYTES) ? expected_bytes
                                                       : 7'(MAX_OUT_BYTES);
  assign avail = (be_r >= cap) ? 7'd0 : (cap - be_r);

  // Next state of the group and the sticky status
  always_comb begin
    buf_nxt = buf_r;
    pos_nxt = pos_r;
    pad_nxt = pad_r;
    be_nxt  = be_r;
    err_nxt = err_r;
    count   = 2'd0;
    nb      = 2'd0;
    if (err_r == b64d_pkg::ST_OK) begin
      if (sx == b64d_pkg::SX_BAD) begin
        err_nxt = b64d_pkg::ST_BADCHAR;
      end else if (pad_r != 2'd0 && pos_r == 2'd0) begin
        err_nxt = b64d_pkg::ST_BADPAD;
      end else if (is_pad && pos_r < 2'd2) begin
        err_nxt = b64d_pkg::ST_BADPAD;
      end else if (!is_pad && pad_r != 2'd0) begin
        err_nxt = b64d_pkg::ST_BADPAD;
      end else begin
        if (is_pad) begin
          pad_nxt = pad_r + 2'd1;
        end
        if (pos_r != 2'd3) begin
          buf_nxt = {buf_r[11:0], six};
          pos_nxt = pos_r + 2'd1;
        end else begin
          // Group complete: emit what the budget allows
          count   = 2'd3 - pad_nxt;
          nb      = (7'(count) <= avail) ? count : avail[1:0];
          be_nxt  = be_r + 7'(nb);
          if (nb != count) begin
            err_nxt = b64d_pkg::ST_LENGTH;
          end
          buf_nxt = 18'd0;
          pos_nxt = 2'd0;
        end
      end
    end
    // End-of-string checks
    if (in_ch.in_last) begin
      if (pos_nxt != 2'd0 && err_nxt == b64d_pkg::ST_OK) begin
        err_nxt = b64d_pkg::ST_BADPAD;
      end
      if (be_nxt != expected_bytes && err_nxt == b64d_pkg::ST_OK) begin
        err_nxt = b64d_pkg::ST_LENGTH;
      end
    end
  end

  // Build the job for the back end
  always_comb begin
    job.word   = {buf_r, six};
    job.nbytes = nb;
    job.last   = in_ch.in_last;
    job.status = in_ch.in_last ? err_nxt : b64d_pkg::ST_OK;
  end

  assign push = accept && (nb != 2'd0 || in_ch.in_last);

  // Advance state on each accepted word; clear at end of string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= 18'd0;
      pos_r <= 2'd0;
      pad_r <= 2'd0;
      be_r  <= 7'd0;
      err_r <= b64d_pkg::ST_OK;
    end else if (accept) begin
      if (in_ch.in_last) begin
        buf_r <= 18'd0;
        pos_r <= 2'd0;
        pad_r <= 2'd0;
        be_r  <= 7'd0;
        err_r <= b64d_pkg::ST_OK;
      end else begin
        buf_r <= buf_nxt;
        pos_r <= pos_nxt;
        pad_r <= pad_nxt;
        be_r  <= be_nxt;
        err_r <= err_nxt;
      end
    end
  end

  // A finished string leaves the front end clean
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.in_last |=> pos_r == 2'd0 && be_r == 7'd0 &&
                                err_r == b64d_pkg::ST_OK)
    else $error("front state not cleared after last word");

  // Once an error is held no byte leaves
  a_no_bytes_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != b64d_pkg::ST_OK |-> nb == 2'd0)
    else $error("byte emitted after sticky error");

endmodule

[hdl/b64d_queue.sv]
// ----------------------------------------------------------------------------
// b64d_queue: short job queue between front and back end
// Circular buffer of jobs with separate read and write pointers.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64d_pkg::job_t      push_job,
  input  logic                pop,
  output b64d_pkg::job_t      head,
  output logic                full,
  output logic                empty
);

  b64d_pkg::job_t               mem_r [b64d_pkg::QDepth];
  logic [b64d_pkg::QPtrW-1:0]   wr_r, wr_nxt;
  logic [b64d_pkg::QPtrW-1:0]   rd_r, rd_nxt;
  logic [b64d_pkg::QPtrW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (b64d_pkg::QPtrW+1)'(b64d_pkg::QDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  // Advance pointers and fill count
  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (b64d_pkg::QPtrW+1)'(push) - (b64d_pkg::QPtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (b64d_pkg::QPtrW+1)'(b64d_pkg::QDepth) && !(push && full) &&
    !(pop && empty))
    else $error("job queue overflow or underflow");

endmodule

[hdl/b64d_back.sv]
// ----------------------------------------------------------------------------
// b64d_back: result serialiser
// Splits a job into result words in an output register, one per ready cycle.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic               clk,
  input  logic               rst_n,
  input  b64d_pkg::job_t     head,
  input  logic               q_empty,
  output logic               pop,
  b64d_out_if.source         out_ch
);

  logic [1:0]  idx_r, idx_nxt;
  logic        vld_r, vld_nxt;
  logic [7:0]  byte_r;
  logic        bv_r;
  logic        last_r;
  logic [1:0]  st_r;

  logic        load;
  logic [1:0]  last_idx;
  logic        final_word;
  logic [7:0]  sel_byte;

  assign load       = !q_empty && (!vld_r || out_ch.ready);
  assign last_idx   = (head.nbytes == 2'd0) ? 2'd0 : head.nbytes - 2'd1;
  assign final_word = (idx_r == last_idx);
  assign pop        = load && final_word;

  // Pick the byte at the current index
  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head.word[23:16];
      2'd1:    sel_byte = head.word[15:8];
      default: sel_byte = head.word[7:0];
    endcase
  end

  always_comb begin
    idx_nxt = load ? (final_word ? 2'd0 : idx_r + 2'd1) : idx_r;
    vld_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      bv_r   <= (head.nbytes != 2'd0);
      byte_r <= (head.nbytes != 2'd0) ? sel_byte : 8'd0;
      last_r <= final_word && head.last;
      st_r   <= (final_word && head.last) ? head.status : b64d_pkg::ST_OK;
    end
  end

  assign out_ch.valid      = vld_r;
  assign out_ch.out_byte   = byte_r;
  assign out_ch.byte_valid = bv_r;
  assign out_ch.out_last   = last_r;
  assign out_ch.status     = st_r;

  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.out_last |-> out_ch.status == b64d_pkg::ST_OK &&
                                         out_ch.byte_valid)
    else $error("status or empty word outside final result");

endmodule

[hdl/base64_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// The first result word of a character is offered once it has passed the job
// queue and the output register, if the queue is empty and the output free.
// Throughput: one character per cycle; results leave one per cycle, so a
// full group of four characters gives three words and the output keeps pace.
// The four-entry job queue absorbs output stalls before input is held.
// Reset: synchronous, active low; clears all string state, expected_bytes=32.
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit: base64 stream decoder top level
// Front end decodes characters, queue decouples, back end emits result words.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit #(
  parameter int MAX_OUT_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  b64d_in_if.sink                       in_ch,
  b64d_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [b64d_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [6:0]       exp_r, exp_nxt;
  logic             cfg_wr;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  b64d_pkg::job_t   push_job;
  b64d_pkg::job_t   head;

  // Register port: single register at word index zero
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == b64d_pkg::REG_EXPECTED);
  assign exp_nxt    = cfg_wr ? cfg_pwdata[6:0] : exp_r;
  assign cfg_prdata = (cfg_paddr[2] == b64d_pkg::REG_EXPECTED) ? {25'd0, exp_r}
                                                                : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= b64d_pkg::ExpReset;
    end else begin
      exp_r <= exp_nxt;
    end
  end

  b64d_front #(
    .MAX_OUT_BYTES (MAX_OUT_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .expected_bytes (exp_r),
    .q_full         (q_full),
    .push           (push),
    .job            (push_job)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  b64d_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the base64 stream decoder
// Drives base64 text one character per word, shadows the decoder in a
// behavioural predictor and checks every result word in order. A short
// directed table is followed by random phases of well-formed and damaged
// strings at several expected lengths, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [7:0] PAD_CHAR  = 8'h3D;
  localparam int         RAND_WORDS = 320;

  typedef struct packed {
    logic [7:0]        data;
    logic              data_vld;
    logic              fin;
    b64d_pkg::status_t st;
  } result_t;

  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

  // One directed step: a character, or a write of expected_bytes held in ch
  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [b64d_pkg::CfgAddrW-1:0] cfg_paddr;
  logic [31:0]                   cfg_pwdata;
  logic [31:0]                   cfg_prdata;
  logic                          cfg_pready;

  b64d_in_if  in_bus ();
  b64d_out_if out_bus ();

  base64_stream_decoder_unit #(.MAX_OUT_BYTES(64)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Decoder shadow state
  logic [6:0]        exp_len;
  logic [17:0]       sx_buf;
  logic [1:0]        grp_pos;
  logic [1:0]        pad_cnt;
  logic [6:0]        byte_cnt;
  b64d_pkg::status_t sticky;

  result_t     pending_q[$];
  logic [7:0]  text_q[$];
  int          err_cnt;
  int          sink_wait;
  bit          idle_on;
  stim_row_t   plan [23];

  always #5 clk = ~clk;

  // Count and print one mismatch
  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic [7:0] alpha(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + v;
    else if (v < 6'd52) return 8'h61 + (v - 6'd26);
    else if (v < 6'd62) return 8'h30 + (v - 6'd52);
    else if (v == 6'd62) return 8'h2B;
    else return 8'h2F;
  endfunction

  // Invert the alphabet by search
  function automatic logic [6:0] char_value(input logic [7:0] ch);
    logic [6:0] v;
    v = b64d_pkg::SX_BAD;
    if (ch == PAD_CHAR) v = b64d_pkg::SX_PAD;
    for (int i = 0; i < 64; i++) begin
      if (alpha(i[5:0]) == ch) v = i[6:0];
    end
    return v;
  endfunction

  // Advance the shadow decoder by one character; queue its results if asked
  task automatic predict_char(input logic [7:0] ch, input logic fin, input bit keep);
    logic [6:0]  v;
    logic [5:0]  six;
    logic [23:0] grp;
    logic [6:0]  cap;
    int          cnt;
    result_t     r;
    result_t     outs[$];
    cap = (exp_len < 7'd64) ? exp_len : 7'd64;
    if (sticky == b64d_pkg::ST_OK) begin
      v = char_value(ch);
      six = (v == b64d_pkg::SX_PAD) ? 6'd0 : v[5:0];
      if (v == b64d_pkg::SX_BAD) sticky = b64d_pkg::ST_BADCHAR;
      else if (pad_cnt != 2'd0 && grp_pos == 2'd0) sticky = b64d_pkg::ST_BADPAD;
      else if (v == b64d_pkg::SX_PAD && grp_pos < 2'd2) sticky = b64d_pkg::ST_BADPAD;
      else if (v != b64d_pkg::SX_PAD && pad_cnt != 2'd0) sticky = b64d_pkg::ST_BADPAD;
      else begin
        if (v == b64d_pkg::SX_PAD) pad_cnt = pad_cnt + 2'd1;
        if (grp_pos < 2'd3) begin
          sx_buf = {sx_buf[11:0], six};
          grp_pos = grp_pos + 2'd1;
        end else begin
          grp = {sx_buf, six};
          cnt = 3 - pad_cnt;
          for (int i = 0; i < cnt && sticky == b64d_pkg::ST_OK; i++) begin
            if (byte_cnt >= cap) begin
              sticky = b64d_pkg::ST_LENGTH;
            end else begin
              r = '{grp[23-8*i -: 8], 1'b1, 1'b0, b64d_pkg::ST_OK};
              outs.push_back(r);
              byte_cnt = byte_cnt + 7'd1;
            end
          end
          sx_buf = '0;
          grp_pos = '0;
        end
      end
    end
    if (fin) begin
      if (grp_pos != 2'd0 && sticky == b64d_pkg::ST_OK) sticky = b64d_pkg::ST_BADPAD;
      if (byte_cnt != exp_len && sticky == b64d_pkg::ST_OK) sticky = b64d_pkg::ST_LENGTH;
      if (outs.size() == 0) begin
        r = '{8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK};
        outs.push_back(r);
      end
      outs[outs.size()-1].fin = 1'b1;
      outs[outs.size()-1].st  = sticky;
      sx_buf = '0;
      grp_pos = '0;
      pad_cnt = '0;
      byte_cnt = '0;
      sticky = b64d_pkg::ST_OK;
    end
    if (keep) begin
      foreach (outs[i]) pending_q.push_back(outs[i]);
    end
  endtask

  // Offer one character word; entered and left at a falling edge
  task automatic send_char(input logic [7:0] ch, input logic fin, input bit keep);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   = 1'b1;
    in_bus.in_char = ch;
    in_bus.in_last = fin;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_char(ch, fin, keep);
    @(negedge clk);
  endtask

  // Hold input until every expected word has come, then let the pipe settle
  task automatic drain_quiet();
    in_bus.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write expected_bytes with junk in the upper bits, then read it back
  task automatic cfg_write(input logic [6:0] len);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {b64d_pkg::REG_EXPECTED, 2'b00};
    cfg_pwdata  = ($urandom() & 32'hFFFF_FF80) | {25'd0, len};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    exp_len = len;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[6:0] !== exp_len)
      flag_error($sformatf("expected_bytes reads %0d, wrote %0d", cfg_prdata[6:0], exp_len));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Encode nbytes random bytes as padded base64 into text_q
  task automatic build_text(input int nbytes);
    logic [23:0] w;
    int          rem;
    text_q.delete();
    for (int g = 0; g < nbytes; g += 3) begin
      rem = nbytes - g;
      w = 24'($urandom());
      if (rem < 3) w[7:0] = 8'h00;
      if (rem < 2) w[15:8] = 8'h00;
      text_q.push_back(alpha(w[23:18]));
      text_q.push_back(alpha(w[17:12]));
      text_q.push_back(rem >= 2 ? alpha(w[11:6]) : PAD_CHAR);
      text_q.push_back(rem >= 3 ? alpha(w[5:0]) : PAD_CHAR);
    end
    if (text_q.size() == 0) text_q.push_back(alpha(6'($urandom_range(0, 63))));
  endtask

  // Damage the text in one of several ways
  task automatic corrupt_text();
    int n;
    int pos;
    n = text_q.size();
    pos = $urandom_range(0, n - 1);
    case ($urandom_range(0, 4))
      0: text_q[pos] = 8'($urandom_range(0, 255));
      1: text_q.insert(pos, PAD_CHAR);
      2: if (n > 1) void'(text_q.pop_back());
      3: text_q.push_back(alpha(6'($urandom_range(0, 63))));
      default: begin
        // set the unused bits of a padded group
        if (n >= 4 && text_q[n-1] == PAD_CHAR)
          text_q[(text_q[n-2] == PAD_CHAR) ? n - 3 : n - 2] =
            alpha(6'($urandom_range(0, 63)));
        else
          text_q.push_back(PAD_CHAR);
      end
    endcase
  endtask

  // Stall the result channel for a drawn number of cycles per word
  always @(negedge clk) begin
    if (sink_wait > 0) begin
      out_bus.ready = 1'b0;
      sink_wait--;
    end else begin
      out_bus.ready = 1'b1;
    end
  end

  // Check each accepted result word against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_q.size() == 0) begin
        flag_error($sformatf("unexpected word byte=%02h vld=%0b last=%0b status=%0d",
                             out_bus.out_byte, out_bus.byte_valid, out_bus.out_last,
                             out_bus.status));
      end else begin
        want = pending_q.pop_front();
        if (out_bus.out_byte !== want.data)
          flag_error($sformatf("out_byte %02h, want %02h", out_bus.out_byte, want.data));
        if (out_bus.byte_valid !== want.data_vld)
          flag_error($sformatf("byte_valid %0b, want %0b", out_bus.byte_valid, want.data_vld));
        if (out_bus.out_last !== want.fin)
          flag_error($sformatf("out_last %0b, want %0b", out_bus.out_last, want.fin));
        if (out_bus.status !== want.st)
          flag_error($sformatf("status %0d, want %0d", out_bus.status, want.st));
      end
      sink_wait = idle_on ? $urandom_range(0, 9) : 0;
    end
  end

  initial begin
    int sent;
    int phase;
    int len;
    int nb;

    clk            = 1'b0;
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.in_char = 8'h00;
    in_bus.in_last = 1'b0;
    out_bus.ready  = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    err_cnt        = 0;
    sink_wait      = 0;
    idle_on        = 1'b0;
    exp_len        = b64d_pkg::ExpReset;
    sx_buf         = '0;
    grp_pos        = '0;
    pad_cnt        = '0;
    byte_cnt       = '0;
    sticky         = b64d_pkg::ST_OK;

    // Directed steps; typed rows carry the single word they must produce
    plan = '{
      '{ROW_CHAR, PAD_CHAR, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, b64d_pkg::ST_BADPAD}},
      '{ROW_CHAR, 8'h00,    1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, b64d_pkg::ST_BADCHAR}},
      '{ROW_CHAR, 8'hFF,    1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, b64d_pkg::ST_BADCHAR}},
      '{ROW_CFG,  8'd3,     1'b0, 1'b0, '0},
      '{ROW_CHAR, "A",      1'b0, 1'b0, '0},
      '{ROW_CHAR, "Z",      1'b0, 1'b0, '0},
      '{ROW_CHAR, "a",      1'b0, 1'b0, '0},
      '{ROW_CHAR, "z",      1'b0, 1'b0, '0},
      '{ROW_CHAR, "0",      1'b0, 1'b0, '0},
      '{ROW_CHAR, "9",      1'b0, 1'b0, '0},
      '{ROW_CHAR, "+",      1'b0, 1'b0, '0},
      '{ROW_CHAR, "/",      1'b1, 1'b0, '0},
      '{ROW_CFG,  8'd1,     1'b0, 1'b0, '0},
      '{ROW_CHAR, "Q",      1'b0, 1'b0, '0},
      '{ROW_CHAR, "R",      1'b0, 1'b0, '0},
      '{ROW_CHAR, PAD_CHAR, 1'b0, 1'b0, '0},
      '{ROW_CHAR, PAD_CHAR, 1'b1, 1'b0, '0},
      '{ROW_CFG,  8'd0,     1'b0, 1'b0, '0},
      '{ROW_CHAR, "A",      1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, b64d_pkg::ST_BADPAD}},
      '{ROW_CHAR, "A",      1'b0, 1'b0, '0},
      '{ROW_CHAR, "B",      1'b0, 1'b0, '0},
      '{ROW_CHAR, PAD_CHAR, 1'b0, 1'b0, '0},
      '{ROW_CHAR, "C",      1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, b64d_pkg::ST_BADPAD}}
    };

    // Hold reset, release on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    idle_on = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_quiet();
        cfg_write(plan[i].ch[6:0]);
      end else begin
        send_char(plan[i].ch, plan[i].fin, !plan[i].typed);
        if (plan[i].typed) pending_q.push_back(plan[i].want);
      end
    end

    // Random phases: one expected length each, several strings per phase
    sent = 0;
    phase = 0;
    while (sent < RAND_WORDS) begin
      drain_quiet();
      if (phase == 0) len = 64;
      else if (phase == 1) len = 127;
      else if ($urandom_range(0, 4) == 0) len = $urandom_range(10, 40);
      else len = $urandom_range(0, 9);
      cfg_write(len[6:0]);
      repeat ($urandom_range(2, 5)) begin
        if (sent < RAND_WORDS) begin
          nb = (len > 64) ? 64 : len;
          case ($urandom_range(0, 5))
            0: nb = nb + $urandom_range(1, 2);
            1: if (nb > 0) nb = nb - 1;
            default: ;
          endcase
          build_text(nb);
          if ($urandom_range(0, 3) == 0) corrupt_text();
          idle_on = ($urandom_range(0, 3) != 0);
          foreach (text_q[i]) begin
            send_char(text_q[i], i == text_q.size() - 1, 1'b1);
            sent++;
          end
        end
      end
      phase++;
    end

    // Drain, let the pipe settle and report
    in_bus.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
